[sv/pbl_pkg.sv]
// shared types and constants for the positional byte list
package pbl_pkg;

   localparam int unsigned MODE_W  = 3;
   localparam int unsigned DATA_W  = 8;
   localparam int unsigned IDX_W   = 8;
   localparam int unsigned STAT_W  = 2;

   // request modes
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_END   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT_AT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_POP_END    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REMOVE_AT  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_READ_AT    = 3'd6;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BEYOND = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

   // one shift operation on the cell row
   typedef struct packed {
      logic              ins;
      logic              rem;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] value;
   } cell_op_type;

endpackage

[sv/pbl_if.sv]
// request and response channel interfaces
interface pbl_req_if
   import pbl_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [DATA_W-1:0] value;
   logic [IDX_W-1:0]  position;

   modport source (output valid, mode, value, position, input ready);
   modport sink   (input valid, mode, value, position, output ready);
endinterface

interface pbl_rsp_if
   import pbl_pkg::*;
#(
   parameter int unsigned SIZE_W = 7
) ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [DATA_W-1:0] read_value;
   logic [DATA_W-1:0] front_value;
   logic [DATA_W-1:0] end_value;
   logic [SIZE_W-1:0] list_size;

   modport source (output valid, status, read_value, front_value, end_value, list_size,
                   input ready);
   modport sink   (input valid, status, read_value, front_value, end_value, list_size,
                   output ready);
endinterface

[sv/pbl_cells.sv]
// row of byte cells with one-place shift for insert and remove, plus read ports
module pbl_cells
   import pbl_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  logic              clock,
   input  cell_op_type       op,
   input  logic [IDX_W-1:0]  rd_idx_a,
   input  logic [IDX_W-1:0]  rd_idx_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b,
   output logic [DATA_W-1:0] head0,
   output logic [DATA_W-1:0] head1
);

   localparam int unsigned AW = $clog2(CAPACITY);

   logic [DATA_W-1:0] cells_ff [CAPACITY];
   logic [DATA_W-1:0] cells_in [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] prev_cell;
      logic [DATA_W-1:0] next_cell;

      if (i == 0) begin : g_first
         assign prev_cell = '0;
      end else begin : g_prev
         assign prev_cell = cells_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_cell = '0;
      end else begin : g_next
         assign next_cell = cells_ff[i+1];
      end

      always_comb begin
         cells_in[i] = cells_ff[i];
         if (op.ins) begin
            if (IDX_W'(i) == op.idx) begin
               cells_in[i] = op.value;
            end else if (IDX_W'(i) > op.idx) begin
               cells_in[i] = prev_cell;
            end
         end else if (op.rem && IDX_W'(i) >= op.idx) begin
            cells_in[i] = next_cell;
         end
      end

      always_ff @(posedge clock) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   assign rd_data_a = (rd_idx_a < IDX_W'(CAPACITY)) ? cells_ff[rd_idx_a[AW-1:0]] : '0;
   assign rd_data_b = (rd_idx_b < IDX_W'(CAPACITY)) ? cells_ff[rd_idx_b[AW-1:0]] : '0;
   assign head0     = cells_ff[0];
   assign head1     = cells_ff[1];

endmodule

[sv/positional_byte_list.sv]
// top level of the positional byte list
//
//   channel   dir   handshake      word
//   req_bus   in    valid/ready    mode, value, position
//   rsp_bus   out   valid/ready    status, read_value, front_value, end_value, list_size
//
// one request per cycle sustained while responses are taken; a request passes through
// the input register, then the cell row update together with the response register
// reset clears the element count and both valid flags; cell contents are not cleared
// a stalled response holds the request stage, which then drops ready once it is full
module positional_byte_list
   import pbl_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   pbl_req_if.sink     req_bus,
   pbl_rsp_if.source   rsp_bus
);

   localparam int unsigned SW = $clog2(CAPACITY + 1);

   // request stage
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [MODE_W-1:0] s1_mode_ff;
   logic [DATA_W-1:0] s1_value_ff;
   logic [IDX_W-1:0]  s1_pos_ff;

   // list state
   logic [SW-1:0]     count_ff;
   logic [SW-1:0]     count_in;

   // response register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [STAT_W-1:0] status_ff;
   logic [DATA_W-1:0] read_value_ff;
   logic [DATA_W-1:0] front_value_ff;
   logic [DATA_W-1:0] end_value_ff;

   logic              advance;
   logic              fire;
   logic              req_take;

   // decode of the staged request
   cell_op_type       op;
   logic [STAT_W-1:0] status_in;
   logic              do_read;
   logic [IDX_W-1:0]  cnt8;
   logic [IDX_W-1:0]  rd_idx;
   logic [IDX_W-1:0]  end_idx;
   logic              full;
   logic              empty;
   logic              pos_lt;
   logic [DATA_W-1:0] rd_data;
   logic [DATA_W-1:0] end_data;
   logic [DATA_W-1:0] head0;
   logic [DATA_W-1:0] head1;
   logic [DATA_W-1:0] front_in;
   logic [DATA_W-1:0] end_in;
   logic [DATA_W-1:0] read_in;

   // response slot frees when empty or being taken; request stage moves into it
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = s1_valid_ff && advance;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   // request payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff  <= req_bus.mode;
         s1_value_ff <= req_bus.value;
         s1_pos_ff   <= req_bus.position;
      end
   end

   // count never exceeds capacity, which fits in the index width
   assign cnt8   = IDX_W'(count_ff);
   assign full   = (count_ff == SW'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign pos_lt = (s1_pos_ff < cnt8);

   // mode decode: status, shift operation and read index
   always_comb begin
      op        = '0;
      op.value  = s1_value_ff;
      status_in = STAT_OK;
      do_read   = 1'b0;
      rd_idx    = pos_lt ? s1_pos_ff : (cnt8 - IDX_W'(1));
      case (s1_mode_ff)
         MODE_PUSH_FRONT, MODE_PUSH_END, MODE_INSERT_AT: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               op.ins = 1'b1;
               if (s1_mode_ff == MODE_PUSH_FRONT) begin
                  op.idx = '0;
               end else if (s1_mode_ff == MODE_PUSH_END) begin
                  op.idx = cnt8;
               end else begin
                  // past the end appends
                  op.idx = pos_lt ? s1_pos_ff : cnt8;
               end
            end
         end
         MODE_POP_FRONT, MODE_POP_END: begin
            if (empty) begin
               status_in = STAT_EMPTY;
            end else begin
               op.rem = 1'b1;
               op.idx = (s1_mode_ff == MODE_POP_FRONT) ? '0 : (cnt8 - IDX_W'(1));
            end
         end
         MODE_REMOVE_AT: begin
            if (empty) begin
               status_in = STAT_EMPTY;
            end else if (!pos_lt) begin
               status_in = STAT_BEYOND;
            end else begin
               op.rem = 1'b1;
               op.idx = s1_pos_ff;
            end
         end
         MODE_READ_AT: begin
            // read past the end clamps to the last element
            if (empty) begin
               status_in = STAT_EMPTY;
            end else begin
               do_read = 1'b1;
            end
         end
         default: begin
            // unused mode: no change
         end
      endcase
      // only shift the row when the request actually moves on
      if (!fire) begin
         op.ins = 1'b0;
         op.rem = 1'b0;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (op.ins) begin
         count_in = count_ff + SW'(1);
      end else if (op.rem) begin
         count_in = count_ff - SW'(1);
      end
   end

   // last element after the request, located in the old row
   assign end_idx = (op.rem && op.idx == cnt8 - IDX_W'(1)) ? (cnt8 - IDX_W'(2))
                                                           : (cnt8 - IDX_W'(1));

   pbl_cells #(
      .CAPACITY (CAPACITY)
   ) u_cells (
      .clock     (clock),
      .op        (op),
      .rd_idx_a  (rd_idx),
      .rd_idx_b  (end_idx),
      .rd_data_a (rd_data),
      .rd_data_b (end_data),
      .head0     (head0),
      .head1     (head1)
   );

   // front and end values as seen after this request
   always_comb begin
      read_in = do_read ? rd_data : '0;
      if (count_in == '0) begin
         front_in = '0;
         end_in   = '0;
      end else begin
         if (op.ins && op.idx == '0) begin
            front_in = op.value;
         end else if (op.rem && op.idx == '0) begin
            front_in = head1;
         end else begin
            front_in = head0;
         end
         if (op.ins && op.idx == cnt8) begin
            end_in = op.value;
         end else begin
            end_in = end_data;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff      <= status_in;
         read_value_ff  <= read_in;
         front_value_ff <= front_in;
         end_value_ff   <= end_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.read_value  = read_value_ff;
   assign rsp_bus.front_value = front_value_ff;
   assign rsp_bus.end_value   = end_value_ff;
   assign rsp_bus.list_size   = count_ff;

endmodule

[sv/pbl_checker.sv]
// port-level checks for the positional byte list, bound to the top level
module pbl_checker
   import pbl_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [STAT_W-1:0]               status,
   input logic [DATA_W-1:0]               read_value,
   input logic [DATA_W-1:0]               front_value,
   input logic [DATA_W-1:0]               end_value,
   input logic [$clog2(CAPACITY+1)-1:0]   list_size
);

   localparam int unsigned SW = $clog2(CAPACITY + 1);

   // size never goes past capacity
   a_size_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> list_size <= SW'(CAPACITY))
      else $error("list size above capacity");

   // empty status leaves an empty list with zero values
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STAT_EMPTY |->
         list_size == '0 && front_value == '0 && end_value == '0 && read_value == '0)
      else $error("empty status with nonzero contents");

   // full status leaves a full list
   a_full_size : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STAT_FULL |-> list_size == SW'(CAPACITY))
      else $error("full status on a list with room");

   // a list of one element has equal front and end
   a_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && list_size == SW'(1) |-> front_value == end_value)
      else $error("single element list with differing front and end");

   // a stalled response word holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
         $stable(read_value) && $stable(front_value) && $stable(end_value) &&
         $stable(list_size))
      else $error("stalled response word changed");

endmodule

bind positional_byte_list pbl_checker #(
   .CAPACITY (CAPACITY)
) u_pbl_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .status      (rsp_bus.status),
   .read_value  (rsp_bus.read_value),
   .front_value (rsp_bus.front_value),
   .end_value   (rsp_bus.end_value),
   .list_size   (rsp_bus.list_size)
);

[tb/pbl_list_checker.sv]
// watches both channels, predicts each response word from its own list copy and compares
module pbl_list_checker
   import pbl_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   pbl_req_if          req_bus,
   pbl_rsp_if          rsp_bus,
   output int unsigned fault_count,
   output int unsigned pending_count,
   output int unsigned checked_count,
   output int unsigned full_hits,
   output int unsigned empty_hits,
   output int unsigned beyond_hits
);

   localparam int unsigned SIZE_W = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] read_value;
      logic [DATA_W-1:0] front_value;
      logic [DATA_W-1:0] end_value;
      logic [SIZE_W-1:0] list_size;
   } list_reply_type;

   logic [DATA_W-1:0] cells [CAPACITY];
   int                held;
   list_reply_type    awaited_replies [$];

   // updates the list copy for one request word and returns the reply it must produce
   function automatic list_reply_type apply_request(input logic [MODE_W-1:0] mode,
                                                    input logic [DATA_W-1:0] value,
                                                    input logic [IDX_W-1:0]  position);
      list_reply_type reply;
      int             slot;
      reply = '0;
      reply.status = STAT_OK;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_END, MODE_INSERT_AT: begin
            if (held >= CAPACITY) begin
               reply.status = STAT_FULL;
            end else begin
               if (mode == MODE_PUSH_FRONT) begin
                  slot = 0;
               end else if (mode == MODE_PUSH_END) begin
                  slot = held;
               end else begin
                  slot = (position < held) ? int'(position) : held;
               end
               for (int i = held; i > slot; i--) cells[i] = cells[i-1];
               cells[slot] = value;
               held++;
            end
         end
         MODE_POP_FRONT, MODE_POP_END, MODE_REMOVE_AT: begin
            if (held == 0) begin
               reply.status = STAT_EMPTY;
            end else if (mode == MODE_REMOVE_AT && position >= held) begin
               reply.status = STAT_BEYOND;
            end else begin
               if (mode == MODE_POP_FRONT) begin
                  slot = 0;
               end else if (mode == MODE_POP_END) begin
                  slot = held - 1;
               end else begin
                  slot = int'(position);
               end
               for (int i = slot; i + 1 < held; i++) cells[i] = cells[i+1];
               held--;
            end
         end
         MODE_READ_AT: begin
            if (held == 0) begin
               reply.status = STAT_EMPTY;
            end else begin
               reply.read_value = cells[(position < held) ? int'(position) : held - 1];
            end
         end
         default: begin
         end
      endcase
      reply.front_value = (held != 0) ? cells[0] : '0;
      reply.end_value   = (held != 0) ? cells[held-1] : '0;
      reply.list_size   = SIZE_W'(held);
      return reply;
   endfunction

   function automatic void check_field(input string tag, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      list_reply_type want;
      if (reset) begin
         held = 0;
         awaited_replies.delete();
         fault_count = 0;
         checked_count = 0;
         full_hits = 0;
         empty_hits = 0;
         beyond_hits = 0;
      end else begin
         // compare first: a response word never belongs to a request taken on the same edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_replies.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual status %0h size %0d",
                        $time, rsp_bus.status, rsp_bus.list_size);
               fault_count++;
            end else begin
               want = awaited_replies.pop_front();
               check_field("status", DATA_W'(want.status), DATA_W'(rsp_bus.status));
               check_field("read_value", want.read_value, rsp_bus.read_value);
               check_field("front_value", want.front_value, rsp_bus.front_value);
               check_field("end_value", want.end_value, rsp_bus.end_value);
               check_field("list_size", DATA_W'(want.list_size), DATA_W'(rsp_bus.list_size));
               checked_count++;
               if (want.status == STAT_FULL) full_hits++;
               if (want.status == STAT_EMPTY) empty_hits++;
               if (want.status == STAT_BEYOND) beyond_hits++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            awaited_replies.push_back(apply_request(req_bus.mode, req_bus.value,
                                                    req_bus.position));
         end
      end
      pending_count = awaited_replies.size();
   end

endmodule

[tb/positional_byte_list_test.sv]
// top of the positional byte list regression: stimulus, response stalls, watchdog and verdict
module positional_byte_list_test;
   import pbl_pkg::*;

   localparam int unsigned LIST_DEPTH   = 64;
   localparam int unsigned SIZE_BITS    = $clog2(LIST_DEPTH + 1);
   localparam int unsigned RANDOM_WORDS = 1500;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 10;

   // mode code the block leaves unused; it must answer ok and change nothing
   localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

   // shape of a random phase
   localparam int unsigned BIAS_GROW   = 0;
   localparam int unsigned BIAS_SHRINK = 1;
   localparam int unsigned BIAS_MIXED  = 2;

   logic clock;
   logic reset;

   pbl_req_if                      req_bus ();
   pbl_rsp_if #(.SIZE_W(SIZE_BITS)) rsp_bus ();

   // when set, the matching side runs without idle cycles for the current phase
   bit send_eager = 1'b0;
   bit take_eager = 1'b0;

   int unsigned words_sent  = 0;
   int unsigned idle_cycles = 0;

   int unsigned fault_count;
   int unsigned pending_count;
   int unsigned checked_count;
   int unsigned full_hits;
   int unsigned empty_hits;
   int unsigned beyond_hits;

   positional_byte_list #(.CAPACITY(LIST_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pbl_list_checker #(.CAPACITY(LIST_DEPTH)) list_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fault_count   (fault_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .full_hits     (full_hits),
      .empty_hits    (empty_hits),
      .beyond_hits   (beyond_hits)
   );

   // 10 time unit clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // offers one request word; entered and left just after a falling edge
   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                            input logic [IDX_W-1:0] position);
      int unsigned gap;
      gap = send_eager ? 0 : $urandom_range(0, 8);
      // valid only drops when a gap is drawn, so back-to-back words keep it high
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.mode     = mode;
      req_bus.value    = value;
      req_bus.position = position;
      // ready seen at the rising edge is the value the block decided on
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // response side: a fresh stall draw for every response word
   initial begin : response_side
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = take_eager ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // watchdog: too long without any word moving on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("positional_byte_list regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned random_sent;
      int unsigned phase_len;
      int unsigned bias;
      int unsigned pick;
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  position;

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.mode     = MODE_PUSH_FRONT;
      req_bus.value    = '0;
      req_bus.position = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every removing and reading mode and the spare code on an empty list
      send_word(MODE_POP_FRONT, 8'h00, 8'h00);
      send_word(MODE_POP_END, 8'h00, 8'h00);
      send_word(MODE_REMOVE_AT, 8'h00, 8'h00);
      send_word(MODE_READ_AT, 8'h00, 8'h00);
      send_word(MODE_SPARE, 8'hff, 8'hff);
      // insert on an empty list lands at the front whatever the position
      send_word(MODE_INSERT_AT, 8'h11, 8'd200);
      send_word(MODE_PUSH_FRONT, 8'hff, 8'h00);
      send_word(MODE_PUSH_END, 8'h00, 8'hff);
      send_word(MODE_INSERT_AT, 8'ha5, 8'd0);
      // insert past the end appends
      send_word(MODE_INSERT_AT, 8'h5a, 8'd255);
      send_word(MODE_INSERT_AT, 8'h3c, 8'd2);
      send_word(MODE_READ_AT, 8'h00, 8'd0);
      send_word(MODE_READ_AT, 8'h00, 8'd3);
      // read past the end gives the last element
      send_word(MODE_READ_AT, 8'h00, 8'd255);
      // remove at exactly the size and far past it are both refused
      send_word(MODE_REMOVE_AT, 8'h00, 8'd6);
      send_word(MODE_REMOVE_AT, 8'h00, 8'd255);
      send_word(MODE_REMOVE_AT, 8'h00, 8'd2);
      send_word(MODE_SPARE, 8'h00, 8'd1);
      send_word(MODE_POP_FRONT, 8'h00, 8'h00);
      send_word(MODE_POP_END, 8'h00, 8'h00);
      send_word(MODE_REMOVE_AT, 8'h00, 8'd0);

      // random phases: growing ones run the list into full, shrinking ones drain it,
      // mixed ones keep it churning; idling on each side is switched per phase
      random_sent = 0;
      while (random_sent < RANDOM_WORDS) begin
         phase_len  = $urandom_range(40, 160);
         bias       = $urandom_range(BIAS_GROW, BIAS_MIXED);
         send_eager = ($urandom_range(0, 3) == 0);
         take_eager = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            if (pick == 99) begin
               mode = MODE_SPARE;
            end else if (bias == BIAS_GROW) begin
               if (pick < 30)      mode = MODE_PUSH_FRONT;
               else if (pick < 55) mode = MODE_PUSH_END;
               else if (pick < 85) mode = MODE_INSERT_AT;
               else if (pick < 90) mode = MODE_READ_AT;
               else if (pick < 93) mode = MODE_POP_FRONT;
               else if (pick < 96) mode = MODE_POP_END;
               else                mode = MODE_REMOVE_AT;
            end else if (bias == BIAS_SHRINK) begin
               if (pick < 25)      mode = MODE_POP_FRONT;
               else if (pick < 50) mode = MODE_POP_END;
               else if (pick < 85) mode = MODE_REMOVE_AT;
               else if (pick < 90) mode = MODE_READ_AT;
               else if (pick < 93) mode = MODE_PUSH_FRONT;
               else if (pick < 96) mode = MODE_PUSH_END;
               else                mode = MODE_INSERT_AT;
            end else begin
               mode = MODE_W'($urandom_range(0, 6));
            end
            // positions mostly near the live range, sometimes anywhere or right at the front
            case ($urandom_range(0, 3))
               0:       position = IDX_W'($urandom_range(0, 255));
               3:       position = IDX_W'($urandom_range(0, 3));
               default: position = IDX_W'($urandom_range(0, LIST_DEPTH + 6));
            endcase
            send_word(mode, DATA_W'($urandom_range(0, 255)), position);
            random_sent++;
         end
      end

      req_bus.valid = 1'b0;
      send_eager    = 1'b0;
      take_eager    = 1'b0;
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d request words, checked %0d response words", words_sent, checked_count);
      $display("full list refusals %0d, empty list hits %0d, beyond end removes %0d",
               full_hits, empty_hits, beyond_hits);
      if (fault_count == 0) begin
         $display("positional_byte_list regression: pass");
      end else begin
         $display("positional_byte_list regression: fail");
      end
      $finish;
   end

endmodule

[positional_byte_list.f]
sv/pbl_pkg.sv
sv/pbl_if.sv
sv/pbl_cells.sv
sv/positional_byte_list.sv
sv/pbl_checker.sv
tb/pbl_list_checker.sv
tb/positional_byte_list_test.sv
